// ===== hw/rtl/hps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants
// Holds the widths, the register indexes and the cell mask struct.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int MASK_W   = 16;  // bits in each harmonic or subharmonic mask register
  localparam int TR_W     = 18;  // transpose ratio, Q4.14
  localparam int CFG_W    = 18;  // widest register
  localparam int IDX_W    = 3;
  localparam int FRAC_W   = 54;  // fraction bits of the phase product
  localparam int PROD_W   = 90;  // full phase product width
  localparam int PHASE_W  = 55;  // low product bits that decide harmonic parity
  localparam int IPART_W  = 36;  // integer part of the phase product

  localparam logic [IDX_W-1:0] REG_HARM_ACT = 3'd0;
  localparam logic [IDX_W-1:0] REG_HARM_INV = 3'd1;
  localparam logic [IDX_W-1:0] REG_SUB_ACT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SUB_INV  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRANSP   = 3'd4;

  localparam logic [TR_W-1:0] TR_UNITY = 18'd16384;

  // Per-cell mask bits. act already includes the invert bit.
  typedef struct packed {
    logic act;
    logic inv;
  } hps_mask_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hps_hcell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_hcell: one harmonic cell
// Adds the phase to the multiple from its neighbor and toggles the sign on odd, or on invert.
// ----------------------------------------------------------------------------
module hps_hcell
  import hps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [PHASE_W-1:0] phase,
  input  wire logic [PHASE_W-1:0] acc_in,
  input  wire logic               sign_in,
  input  wire hps_mask_t          mask,
  output logic      [PHASE_W-1:0] acc_out,
  output logic                    sign_out
);

  logic [PHASE_W-1:0] sum;

  assign sum = acc_in + phase;

  // Bit 54 of the running multiple is the parity of its integer part.
  always_ff @(posedge clk) begin
    acc_out  <= sum;
    sign_out <= sign_in ^ (sum[FRAC_W] & mask.act) ^ mask.inv;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hps_scell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hps_scell: one subharmonic cell
// Finds the parity of the integer phase over a fixed divisor in two stages.
// ----------------------------------------------------------------------------
module hps_scell
  import hps_pkg::*;
#(
  parameter int DIV = 2
) (
  input  wire logic               clk,
  input  wire logic [IPART_W-1:0] ipart,
  input  wire logic               sign_in,
  input  wire hps_mask_t          mask,
  output logic                    sign_out
);

  // The phase is split as xh * 2^18 + xl. Then x / DIV has the quotient
  // xh * QUO_HALF + (xh * REM_HALF + xl) / DIV, and the second part is
  // small enough for an exact multiply by a rounded-up reciprocal.
  localparam int HALF_W   = IPART_W / 2;
  localparam int L        = $clog2(DIV);
  localparam int YW       = HALF_W + L;
  localparam int SH       = YW + L;
  localparam int MW       = YW + 1;
  localparam int PW       = YW + MW;
  localparam int QUO_HALF = (1 << HALF_W) / DIV;
  localparam int REM_HALF = (1 << HALF_W) % DIV;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);

  localparam logic [L-1:0]  REM_C   = L'(REM_HALF);
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);
  localparam logic          QUO_ODD = (QUO_HALF % 2 == 1) ? 1'b1 : 1'b0;

  logic [HALF_W-1:0] xh;
  logic [HALF_W-1:0] xl;
  logic [YW-1:0]     y;
  logic [YW-1:0]     y_q;
  logic              hpar_q;
  logic [PW-1:0]     prod;
  logic              qbit;

  assign xh   = ipart[IPART_W-1:HALF_W];
  assign xl   = ipart[HALF_W-1:0];
  assign y    = YW'(xh) * YW'(REM_C) + YW'(xl);
  assign prod = PW'(y_q) * PW'(RECIP_C);

  always_ff @(posedge clk) begin
    y_q    <= y;
    hpar_q <= xh[0] & QUO_ODD;
    qbit   <= prod[SH] ^ hpar_q;
  end

  // Once y_q and then qbit are registered, qbit is the parity of the quotient.
  always_ff @(posedge clk) begin
    sign_out <= sign_in ^ (qbit & mask.act) ^ mask.inv;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/harmonic_parity_sign_modulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// harmonic_parity_sign_modulator: sign modifier from harmonic phase parity
// Forms the note phase product and runs it through a row of harmonic and
// subharmonic cells that toggle a running sign; emits it on the last note.
// ----------------------------------------------------------------------------
//  channel | signals                                        | beat
//  note in | in_valid, in_stall, note_* , last_note         | one note
//  sign out| out_valid, out_stall, sign_negative            | one sign per sample
//  config  | cfg_we, cfg_index, cfg_data                    | one register write
//
// A present note passes through the partial products, the shared multiplier,
// the load of the row, the row run and the emit state. The harmonic chain
// registers once per cell, and the subharmonic cells register their parity
// before their sign chain starts. An absent note goes straight to the emit
// state. Notes are taken one at a time; in_stall is high while one is in
// work, and a last note also waits while an earlier sign beat is stalled.
// Reset clears the running sign and out_valid and sets the configuration registers to defaults.
// ----------------------------------------------------------------------------
module harmonic_parity_sign_modulator
  import hps_pkg::*;
#(
  parameter int NUM_HARMONICS    = 16,
  parameter int NUM_SUBHARMONICS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [31:0]       note_time,
  input  wire logic [15:0]       note_bend,
  input  wire logic [23:0]       note_pitch_hz,
  input  wire logic              note_present,
  input  wire logic              last_note,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   sign_negative,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  localparam int NH      = NUM_HARMONICS;
  localparam int NS      = NUM_SUBHARMONICS;
  localparam int SUB_LAT = 2;
  localparam int RUN_LEN = ((NH > SUB_LAT) ? NH : SUB_LAT) + NS;
  localparam int CW      = $clog2(RUN_LEN + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRE  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_RUN  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  // Configuration registers.
  logic [MASK_W-1:0] harm_act;
  logic [MASK_W-1:0] harm_inv;
  logic [MASK_W-1:0] sub_act;
  logic [MASK_W-1:0] sub_inv;
  logic [TR_W-1:0]   transp;

  always_ff @(posedge clk) begin
    if (rst) begin
      harm_act <= '0;
      harm_inv <= '0;
      sub_act  <= '0;
      sub_inv  <= '0;
      transp   <= TR_UNITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HARM_ACT: harm_act <= cfg_data[MASK_W-1:0];
        REG_HARM_INV: harm_inv <= cfg_data[MASK_W-1:0];
        REG_SUB_ACT:  sub_act  <= cfg_data[MASK_W-1:0];
        REG_SUB_INV:  sub_inv  <= cfg_data[MASK_W-1:0];
        REG_TRANSP:   transp   <= cfg_data[TR_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic          running;
  logic          is_last;
  logic          present;
  logic          emit_go;

  // Note payload and arithmetic.
  logic [31:0]          t_q;
  logic [15:0]          bend_q;
  logic [23:0]          hz_q;
  logic [47:0]          a_q;
  logic [41:0]          b_q;
  logic [PROD_W-1:0]    p_acc;
  logic [PHASE_W-1:0]   phase;
  logic [IPART_W-1:0]   ipart;
  logic [23:0]          a_sel;
  logic [20:0]          b_sel;
  logic [44:0]          pp;
  logic [PROD_W-1:0]    pp_sh;
  logic                 final_sign;

  // One shared 24x21 multiplier builds the 48x42 product from four partial products.
  assign a_sel = cnt[0] ? a_q[47:24] : a_q[23:0];
  assign b_sel = cnt[1] ? b_q[41:21] : b_q[20:0];
  assign pp    = a_sel * b_sel;

  always_comb begin
    unique case (cnt[1:0])
      2'd0: pp_sh = PROD_W'(pp);
      2'd1: pp_sh = PROD_W'(pp) << 24;
      2'd2: pp_sh = PROD_W'(pp) << 21;
      default: pp_sh = PROD_W'(pp) << 45;
    endcase
  end

  // Cell row: harmonic cells first, then the subharmonic cells.
  logic [PHASE_W-1:0] hacc  [0:NH];
  logic               hsign [0:NH];
  logic               ssign [0:NS];

  assign hacc[0]  = '0;
  assign hsign[0] = running;
  assign ssign[0] = hsign[NH];

  for (genvar i = 0; i < NH; i++) begin : g_harm
    hps_mask_t m;
    if (i < MASK_W) begin : g_m
      assign m.act = harm_act[i] | harm_inv[i];
      assign m.inv = harm_inv[i];
    end else begin : g_z
      assign m = '0;
    end
    hps_hcell u_cell (
      .clk      (clk),
      .phase    (phase),
      .acc_in   (hacc[i]),
      .sign_in  (hsign[i]),
      .mask     (m),
      .acc_out  (hacc[i+1]),
      .sign_out (hsign[i+1])
    );
  end

  for (genvar j = 0; j < NS; j++) begin : g_sub
    hps_mask_t m;
    if (j < MASK_W) begin : g_m
      assign m.act = sub_act[j] | sub_inv[j];
      assign m.inv = sub_inv[j];
    end else begin : g_z
      assign m = '0;
    end
    hps_scell #(.DIV(j + 2)) u_cell (
      .clk      (clk),
      .ipart    (ipart),
      .sign_in  (ssign[j]),
      .mask     (m),
      .sign_out (ssign[j+1])
    );
  end

  assign final_sign = present ? ssign[NS] : running;
  assign in_stall   = (state != ST_IDLE);
  assign emit_go    = (state == ST_EMIT) && is_last && (!out_valid || !out_stall);

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        t_q    <= note_time;
        bend_q <= note_bend;
        hz_q   <= note_pitch_hz;
      end
      ST_PRE: begin
        a_q   <= t_q * bend_q;
        b_q   <= hz_q * transp;
        p_acc <= '0;
      end
      ST_MUL: begin
        p_acc <= p_acc + pp_sh;
      end
      ST_LOAD: begin
        phase <= p_acc[PHASE_W-1:0];
        ipart <= p_acc[PROD_W-1:FRAC_W];
      end
      default: ;
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      running   <= 1'b0;
      is_last   <= 1'b0;
      present   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            is_last <= last_note;
            present <= note_present;
            state   <= note_present ? ST_PRE : ST_EMIT;
          end
        end
        ST_PRE: begin
          cnt   <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt[1:0] == 2'd3) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt   <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(RUN_LEN - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!is_last) begin
            running <= final_sign;
            state   <= ST_IDLE;
          end else if (emit_go) begin
            sign_negative <= final_sign;
            running       <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for harmonic_parity_sign_modulator
// Drives notes with random gaps and stalls, predicts the sign of each sample
// from a bit-exact phase product, and checks every sign beat in order.
// ----------------------------------------------------------------------------
module testbench;
  import hps_pkg::*;

  localparam int LATENCY   = 80;
  localparam int WDOG_MAX  = 5000;  // cycles with no beat before giving up
  localparam int N_HARM    = 16;

  // One row of the directed table. Where known is set, the sign is typed in.
  typedef struct packed {
    logic [31:0] t;
    logic [15:0] b;
    logic [23:0] h;
    logic        pres;
    logic        last;
    logic        known;
    logic        sign;
  } note_row_t;

  localparam note_row_t DIRECTED [15] = '{
    // An absent note that ends the sample gives a positive sign.
    '{32'h0, 16'h0, 24'h0, 1'b0, 1'b1, 1'b1, 1'b0},
    // Zero time: every count is zero, and the two invert bits cancel.
    '{32'h0, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
    // Zero bend and zero pitch act the same way.
    '{32'hFFFFFFFF, 16'h0, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
    '{32'hFFFFFFFF, 16'hFFFF, 24'h0, 1'b1, 1'b1, 1'b1, 1'b0},
    // Largest product.
    '{32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
    // A chord of three notes, the first one second of 440 Hz at unity bend.
    '{32'h00010000, 16'h4000, 24'h06E000, 1'b1, 1'b0, 1'b0, 1'b0},
    '{32'h00018000, 16'h4000, 24'h037000, 1'b1, 1'b0, 1'b0, 1'b0},
    '{32'h00007FFF, 16'h8001, 24'h0A5000, 1'b1, 1'b1, 1'b0, 1'b0},
    // A present note followed by an absent last note keeps its toggles.
    '{32'h12345678, 16'h3FFF, 24'h0001FF, 1'b1, 1'b0, 1'b0, 1'b0},
    '{32'h0, 16'h0, 24'h0, 1'b0, 1'b1, 1'b0, 1'b0},
    // Absent notes in the middle of a sample do nothing.
    '{32'hAAAAAAAA, 16'h5555, 24'hAAAAAA, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h55555555, 16'hAAAA, 24'h555555, 1'b1, 1'b1, 1'b0, 1'b0},
    // Smallest nonzero fields.
    '{32'h1, 16'h1, 24'h1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{32'hFFFF0000, 16'hC000, 24'hFFFC00, 1'b1, 1'b1, 1'b0, 1'b0},
    '{32'h0000FFFF, 16'h7FFF, 24'h0003FF, 1'b1, 1'b1, 1'b0, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [31:0]       note_time = '0;
  logic [15:0]       note_bend = '0;
  logic [23:0]       note_pitch_hz = '0;
  logic              note_present = 1'b0;
  logic              last_note = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              sign_negative;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  harmonic_parity_sign_modulator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .note_time(note_time), .note_bend(note_bend), .note_pitch_hz(note_pitch_hz),
    .note_present(note_present), .last_note(last_note),
    .out_valid(out_valid), .out_stall(out_stall), .sign_negative(sign_negative),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the registers and the running sign.
  logic [MASK_W-1:0] harm_act, harm_inv, sub_act, sub_inv;
  logic [TR_W-1:0]   transpose;
  logic              run_sign;

  logic   sign_q[$];        // signs still owed by the block
  int     errors = 0;
  int     idle_cycles = 0;
  bit     sender_gaps = 1'b1;
  bit     sink_gaps = 1'b1;
  bit     hold_sink = 1'b0; // asks the receiver for one long hold-off

  // Toggles the shadow sign for one note and returns 1 with the sign to
  // expect when the note ends the sample.
  function automatic bit sign_predict(input logic [31:0] t, input logic [15:0] b,
                                      input logic [23:0] h, input logic pres,
                                      input logic last, output logic sgn);
    logic [127:0]     phase, scaled;
    logic [IPART_W-1:0] ipart;
    logic [MASK_W-1:0] act;
    if (pres) begin
      phase = 128'(t) * 128'(b) * 128'(h) * 128'(transpose);
      ipart = phase[FRAC_W +: IPART_W];
      // Harmonic k: parity of floor(p*k) is bit FRAC_W of the scaled product.
      act = harm_act | harm_inv;
      for (int k = 1; k <= N_HARM; k++) begin
        scaled = phase * 128'(k);
        if (scaled[FRAC_W] && act[k-1]) run_sign ^= 1'b1;
        if (harm_inv[k-1]) run_sign ^= 1'b1;
      end
      // Subharmonic j divides the integer part by j+1.
      act = sub_act | sub_inv;
      for (int j = 1; j <= N_HARM; j++) begin
        if (((ipart / (j + 1)) & 1) && act[j-1]) run_sign ^= 1'b1;
        if (sub_inv[j-1]) run_sign ^= 1'b1;
      end
    end
    sgn = run_sign;
    if (last) run_sign = 1'b0;
    return last;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_HARM_ACT: harm_act  = val[MASK_W-1:0];
      REG_HARM_INV: harm_inv  = val[MASK_W-1:0];
      REG_SUB_ACT:  sub_act   = val[MASK_W-1:0];
      REG_SUB_INV:  sub_inv   = val[MASK_W-1:0];
      REG_TRANSP:   transpose = val[TR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Registers change only with no note in work: every sign has come out and
  // a trailing note without a result has had time to finish.
  task automatic settle();
    wait (sign_q.size() == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] ha, input logic [CFG_W-1:0] hi,
                           input logic [CFG_W-1:0] sa, input logic [CFG_W-1:0] si,
                           input logic [CFG_W-1:0] tr);
    settle();
    write_reg(REG_HARM_ACT, ha);
    write_reg(REG_HARM_INV, hi);
    write_reg(REG_SUB_ACT, sa);
    write_reg(REG_SUB_INV, si);
    write_reg(REG_TRANSP, tr);
    // Indexes past the last register must leave everything alone.
    write_reg(IDX_W'($urandom_range(5, 7)), CFG_W'($urandom));
  endtask

  // Offers one note and holds it until the block takes it.
  task automatic send_note(input note_row_t row);
    logic sgn;
    if (sender_gaps) begin
      in_valid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    in_valid = 1'b1;
    note_time = row.t;
    note_bend = row.b;
    note_pitch_hz = row.h;
    note_present = row.pres;
    last_note = row.last;
    do @(posedge clk); while (in_stall);
    if (sign_predict(row.t, row.b, row.h, row.pres, row.last, sgn))
      sign_q.push_back(row.known ? row.sign : sgn);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic note_row_t random_note();
    note_row_t row;
    case ($urandom_range(0, 3))
      0: row.t = $urandom;
      1: row.t = 32'($urandom_range(0, 32'h3FFFF));
      default: row.t = 32'($urandom_range(0, 32'h1FFFFF));
    endcase
    row.b = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(12000, 20000));
    row.h = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                        : 24'($urandom_range(20 << 10, 4000 << 10));
    row.pres = ($urandom_range(0, 9) != 0);
    row.last = ($urandom_range(0, 2) == 0);
    row.known = 1'b0;
    row.sign = 1'b0;
    return row;
  endfunction

  // Receiver: random stall, with one long hold-off counted here on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_sink = 1'b0;
        out_stall = 1'b0;
      end else if (sink_gaps && pick_gap() > 0) begin
        out_stall = 1'b1;
        repeat (pick_gap()) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Checks each sign beat against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sign_q.size() == 0) begin
        errors++;
        $display("%0t: sign beat with none expected, actual %0b", $time, sign_negative);
      end else begin
        if (sign_negative !== sign_q[0]) begin
          errors++;
          $display("%0t: sign_negative expected %0b actual %0b",
                   $time, sign_q[0], sign_negative);
        end
        void'(sign_q.pop_front());
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    note_row_t row;
    harm_act = '0;
    harm_inv = '0;
    sub_act = '0;
    sub_inv = '0;
    transpose = TR_UNITY;
    run_sign = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Defaults straight after reset: nothing is active, so signs stay positive.
    for (int n = 0; n < 20; n++) send_note(random_note());

    // Directed table. One invert bit overlaps an active bit and the other has
    // no active bit, so the two cancel on every present note.
    configure(18'h3FFFF, 18'h08000, 18'h07FFE, 18'h00001, TR_UNITY);
    foreach (DIRECTED[i]) send_note(DIRECTED[i]);

    // Random phases over several settings, extremes first.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: configure('0, '0, '0, '0, '0);
        1: configure(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
        2: configure(18'hFFFF, '0, 18'hFFFF, '0, 18'h3FFFF);
        default: configure(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                           CFG_W'($urandom),
                           ($urandom_range(0, 1) != 0) ? TR_UNITY : CFG_W'($urandom));
      endcase
      sender_gaps = (ph != 3);
      sink_gaps = (ph != 3);
      for (int n = 0; n < 80; n++) begin
        // Long receiver hold-off while notes keep coming, so the block fills.
        if (ph == 4 && n == 10) hold_sink = 1'b1;
        // A pause of the sender until every owed sign has drained.
        if (ph == 5 && n == 40) wait (sign_q.size() == 0);
        row = random_note();
        send_note(row);
      end
    end

    settle();
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hps_pkg.sv
hw/rtl/hps_hcell.sv
hw/rtl/hps_scell.sv
hw/rtl/harmonic_parity_sign_modulator.sv
dv/testbench.sv
